FILE: hw/rtl/metaball_supersample_render_defines.svh
// Assertion macros shared by the metaball renderer RTL.
`ifndef METABALL_SUPERSAMPLE_RENDER_DEFINES_SVH
`define METABALL_SUPERSAMPLE_RENDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MSR_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSR_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/msr_pkg.sv
// Shared types, constants and weight table for the metaball renderer.
package msr_pkg;

	localparam int          DEF_MAX_WIDTH = 1024;
	localparam int          LINE_ROWS     = 5;
	localparam int          QMAX          = 450;
	localparam logic [25:0] WSAT          = 26'h3FFFFFF;

	localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;

	// One output pixel job: 6x6 ink window (column-major, 6 rows per column).
	typedef struct packed {
		logic [35:0] window;
		logic        last;
	} job_t;

	typedef logic [25:0] wrom_t [0:QMAX];

	// Largest n with n^5 * q^11 <= 2^124, i.e. floor(65536 * (16/q)^2.2).
	function automatic logic [25:0] weight_calc(input int q);
		logic [255:0] qp;
		logic [255:0] x;
		logic [26:0]  lo;
		logic [26:0]  hi;
		logic [26:0]  mid;
		qp = 256'd1;
		for (int k = 0; k < 11; k++)
			qp = qp * 256'(q);
		lo = 27'd0;
		hi = 27'(WSAT);
		for (int it = 0; it < 28; it++) begin
			if (lo < hi) begin
				mid = lo + ((hi - lo + 27'd1) >> 1);
				x = qp;
				for (int k = 0; k < 5; k++)
					x = x * 256'(mid);
				if (x <= (256'd1 << 124))
					lo = mid;
				else
					hi = mid - 27'd1;
			end
		end
		return lo[25:0];
	endfunction

	function automatic wrom_t build_rom();
		wrom_t r;
		r[0] = WSAT;
		for (int q = 1; q <= QMAX; q++)
			r[q] = weight_calc(q);
		return r;
	endfunction

	localparam wrom_t WEIGHT_ROM = build_rom();

	// Squared distance times 16 from subsample phase to window cell.
	function automatic logic [8:0] q_index(input int cp, input int rp, input logic [3:0] ph);
		int dx;
		int dy;
		dx = int'(ph[1:0]) - 4 * (cp - 3);
		dy = int'(ph[3:2]) - 4 * (rp - 3);
		return 9'(dx * dx + dy * dy);
	endfunction

endpackage

FILE: hw/rtl/msr_front.sv
// Front end: raster position, line store and 6x6 window, emits pixel jobs.
module msr_front #(
	parameter int MAX_WIDTH = msr_pkg::DEF_MAX_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic [7:0]    pixel_byte,
	input  logic          flush,
	input  logic          wr_en,
	input  logic [1:0]    wr_index,
	input  logic [12:0]   wr_data,
	output logic          push,
	output msr_pkg::job_t job,
	input  logic          full
);
	import msr_pkg::*;

	localparam int ADDR_W = $clog2(MAX_WIDTH);

	typedef enum logic [1:0] {ST_IDLE, ST_MERGE, ST_EMIT} state_t;

	state_t       state_q;
	logic [10:0]  width_q;
	logic [12:0]  height_q;
	logic [10:0]  col_q;
	logic [13:0]  row_q;
	logic [2:0]   rm_q;
	logic [10:0]  c_q;
	logic [13:0]  r_q;
	logic [2:0]   crm_q;
	logic         ink_q;
	logic [35:0]  win_q;
	logic [1:0]   step_q;
	logic [4:0]   rdata_q;
	logic [4:0]   mem [MAX_WIDTH];

	logic [10:0]  w_eff;
	logic [13:0]  h_eff;
	logic         restart;
	logic [10:0]  c_acc;
	logic [13:0]  r_acc;
	logic [2:0]   rm_acc;
	logic         accept;
	logic [5:0]   bits;
	logic [4:0]   wword;
	logic         lastcol;
	logic         need;
	logic         done;
	logic [ADDR_W-1:0] rd_addr;
	logic [ADDR_W-1:0] wr_addr;

	always_comb begin
		w_eff = width_q;
		if (width_q == 11'd0)
			w_eff = 11'd1;
		else if (int'(width_q) > MAX_WIDTH)
			w_eff = 11'(MAX_WIDTH);
		h_eff = {1'b0, height_q};
		if (height_q == 13'd0)
			h_eff = 14'd1;
		else if (height_q > 13'd4096)
			h_eff = 14'd4096;
	end

	assign accept  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign restart = (col_q >= w_eff) || (row_q >= h_eff + 14'd2);
	assign c_acc   = restart ? 11'd0 : col_q;
	assign r_acc   = restart ? 14'd0 : row_q;
	assign rm_acc  = restart ? 3'd0 : rm_q;
	assign lastcol = (c_q == w_eff - 11'd1);
	assign rd_addr = ADDR_W'(c_acc);
	assign wr_addr = ADDR_W'(c_q);

	// Older rows of this column come from the line store, newest from the input.
	always_comb begin
		logic [3:0] idx;
		bits  = '0;
		wword = rdata_q;
		for (int j = 0; j < LINE_ROWS; j++) begin
			idx = 4'(crm_q) + 4'(j);
			if (idx >= 4'd5)
				idx = idx - 4'd5;
			if (r_q >= 14'(LINE_ROWS - j))
				bits[j] = rdata_q[idx[2:0]];
		end
		bits[5] = ink_q;
		wword[crm_q] = ink_q;
	end

	always_comb begin
		case (step_q)
			2'd0: need = (r_q >= 14'd2) && (c_q >= 11'd2);
			2'd1: need = lastcol && (r_q >= 14'd2) && (c_q >= 11'd1);
			2'd2: need = lastcol && (r_q >= 14'd2);
			default: need = 1'b0;
		endcase
		done = (step_q == 2'd2) || (step_q == 2'd0 && !lastcol);
	end

	assign push       = (state_q == ST_EMIT) && need;
	assign job.window = win_q;
	assign job.last   = (step_q == 2'd2) || (step_q == 2'd0 && !lastcol);

	always_ff @(posedge clk) begin
		if (accept)
			rdata_q <= mem[rd_addr];
		if (state_q == ST_MERGE)
			mem[wr_addr] <= wword;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			width_q  <= 11'd1024;
			height_q <= 13'd1024;
			col_q    <= '0;
			row_q    <= '0;
			rm_q     <= '0;
			win_q    <= '0;
			step_q   <= '0;
			c_q      <= '0;
			r_q      <= '0;
			crm_q    <= '0;
			ink_q    <= 1'b0;
		end else begin
			if (wr_en && (wr_index == CFG_IMAGE_WIDTH || wr_index == CFG_IMAGE_HEIGHT)) begin
				if (wr_index == CFG_IMAGE_WIDTH)
					width_q <= wr_data[10:0];
				else
					height_q <= wr_data;
				col_q <= '0;
				row_q <= '0;
				rm_q  <= '0;
				win_q <= '0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						c_q     <= c_acc;
						r_q     <= r_acc;
						crm_q   <= rm_acc;
						ink_q   <= !flush && (pixel_byte == 8'd0) && (r_acc < h_eff);
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					win_q <= ((c_q == 11'd0) ? 36'd0 : (win_q >> 6)) | {bits, 30'd0};
					if (c_q + 11'd1 >= w_eff) begin
						col_q <= '0;
						if (r_q + 14'd1 >= h_eff + 14'd2) begin
							row_q <= '0;
							rm_q  <= '0;
						end else begin
							row_q <= r_q + 14'd1;
							rm_q  <= (crm_q == 3'd4) ? 3'd0 : crm_q + 3'd1;
						end
					end else begin
						col_q <= c_q + 11'd1;
					end
					step_q  <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!(need && full)) begin
						if (done) begin
							state_q <= ST_IDLE;
						end else begin
							step_q <= step_q + 2'd1;
							win_q  <= win_q >> 6;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

FILE: hw/rtl/msr_queue.sv
// Two-entry job queue between front end and subsample engine.
`include "metaball_supersample_render_defines.svh"
module msr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  msr_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          empty,
	output msr_pkg::job_t head
);
	import msr_pkg::*;

	job_t       slot_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	logic       do_push;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign head    = slot_q[rp_q];
	assign do_push = push && !full;

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wp_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wp_q <= !wp_q;
			if (pop)
				rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(pop);
		end
	end

	`MSR_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= 2'd2, "queue count above depth")
	`MSR_ASSERT_IMP(a_no_pop_empty, clk, arst_n, pop, !empty, "pop from empty queue")
	`MSR_ASSERT_NXT(a_push_held, clk, arst_n, push && full, push && $stable(push_job),
		"job dropped while queue full")

endmodule

FILE: hw/rtl/msr_back.sv
// Subsample engine: one phase per cycle unless the output stalls, weight sum, smoothstep, 16-way average.
module msr_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          empty,
	input  msr_pkg::job_t head,
	output logic          pop,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [7:0]    grey,
	output logic          last
);
	import msr_pkg::*;

	typedef struct packed {
		logic vld;
		logic fin;
		logic last;
	} tag_t;

	logic        adv;
	logic [3:0]  ph_q;
	tag_t        tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7, tag_s8;
	logic [35:0] win_s1;
	logic [3:0]  ph_s1;
	logic [28:0] grp_s2 [6];
	logic [25:0] sum_s3;
	logic [17:0] u_s4;
	logic [19:0] t_s4;
	logic        lo_s4, hi_s4, lo_s5, hi_s5, lo_s6, hi_s6, lo_s7, hi_s7, lo_s8, hi_s8;
	logic [35:0] uu_s5;
	logic [19:0] t_s5;
	logic [55:0] p_s6;
	logic [12:0] n_s7;
	logic [7:0]  q_s8;
	logic [11:0] acc_q;
	logic        out_valid_q;
	logic [7:0]  grey_q;
	logic        last_q;

	logic [28:0] grp [6];
	logic [31:0] total;
	logic [16:0] dlt;
	logic [20:0] u_full;
	logic [63:0] p255;
	logic [26:0] nrec;
	logic [7:0]  level;

	assign adv = !out_valid_q || !out_stall;
	assign pop = adv && !empty && (ph_q == 4'd15);

	assign out_valid = out_valid_q;
	assign grey      = grey_q;
	assign last      = last_q;

	// Gate table weights by window ink, summed per window column.
	always_comb begin
		for (int g = 0; g < 6; g++) begin
			grp[g] = '0;
			for (int r = 0; r < 6; r++)
				if (win_s1[g * 6 + r])
					grp[g] = grp[g] + 29'(WEIGHT_ROM[q_index(g, r, ph_s1)]);
		end
		total = '0;
		for (int g = 0; g < 6; g++)
			total = total + 32'(grp_s2[g]);
	end

	always_comb begin
		dlt    = 17'(27'd65536 - 27'(sum_s3));
		u_full = 21'(dlt) * 21'd10;
		p255   = {p_s6, 8'd0} - 64'(p_s6);
		nrec   = 27'(n_s7) * 27'd9710;
		level  = lo_s8 ? 8'd0 : (hi_s8 ? 8'd255 : q_s8);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			win_s1 <= head.window;
			ph_s1  <= ph_q;
			grp_s2 <= grp;
			sum_s3 <= (total > 32'(WSAT)) ? WSAT : total[25:0];
			lo_s4  <= (sum_s3 >= 26'd65536);
			hi_s4  <= (u_full >= 21'd196608);
			u_s4   <= u_full[17:0];
			t_s4   <= 20'd589824 - {1'b0, u_full[17:0], 1'b0};
			uu_s5  <= 36'(u_s4) * 36'(u_s4);
			t_s5   <= t_s4;
			lo_s5  <= lo_s4;
			hi_s5  <= hi_s4;
			p_s6   <= 56'(uu_s5) * 56'(t_s5);
			lo_s6  <= lo_s5;
			hi_s6  <= hi_s5;
			n_s7   <= p255[60:48];
			lo_s7  <= lo_s6;
			hi_s7  <= hi_s6;
			q_s8   <= nrec[25:18];
			lo_s8  <= lo_s7;
			hi_s8  <= hi_s7;
			if (tag_s8.vld && tag_s8.fin) begin
				grey_q <= 8'((acc_q + 12'(level)) >> 4);
				last_q <= tag_s8.last;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= '0;
			tag_s1      <= '0;
			tag_s2      <= '0;
			tag_s3      <= '0;
			tag_s4      <= '0;
			tag_s5      <= '0;
			tag_s6      <= '0;
			tag_s7      <= '0;
			tag_s8      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			if (!empty)
				ph_q <= ph_q + 4'd1;
			tag_s1 <= '{vld: !empty, fin: (ph_q == 4'd15), last: head.last};
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
			tag_s5 <= tag_s4;
			tag_s6 <= tag_s5;
			tag_s7 <= tag_s6;
			tag_s8 <= tag_s7;
			if (tag_s8.vld)
				acc_q <= tag_s8.fin ? 12'd0 : acc_q + 12'(level);
			out_valid_q <= tag_s8.vld && tag_s8.fin;
		end
	end

endmodule

FILE: hw/rtl/metaball_supersample_render.sv
// Metaball supersample renderer: top level tying front end, job queue and engine.
// An accepted beat passes the front end, the job queue, 16 subsample phases, the pipeline
// and the output register. Throughput: one subsample phase per cycle while out_stall is
// not holding the output; the front end takes a new beat only once the jobs of the last
// one are pushed, and waits while the job queue is full.
// Reset: arst_n clears position, window, queue and pipeline; width and height go to 1024.
module metaball_supersample_render #(
	parameter int MAX_WIDTH = msr_pkg::DEF_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  pixel_byte,
	input  logic        flush,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  grey,
	output logic        last,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [12:0] wr_data
);
	import msr_pkg::*;

	// Front-to-queue job handoff.
	logic push;
	job_t push_job;
	logic full;

	// Queue-to-engine handoff.
	logic pop;
	logic empty;
	job_t head;

	// Track raster position, keep five rows of ink bits and the 6x6 window,
	// and emit one job per output pixel (up to three on a row's last column).
	// The line store is not cleared; rows above the frame top are never read.
	msr_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pixel_byte(pixel_byte),
		.flush     (flush),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.push      (push),
		.job       (push_job),
		.full      (full)
	);

	// Hold up to two jobs so the front end keeps taking beats while the engine works.
	msr_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.full    (full),
		.pop     (pop),
		.empty   (empty),
		.head    (head)
	);

	// Sweep 16 subsample phases per job; the output register parts engine and sink.
	msr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (empty),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.grey     (grey),
		.last     (last)
	);

endmodule
